// ===== design/asrow_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asrow_pkg
// Shared constants, register codes and bundle types of the autostereogram
// row engine.
// ---------------------------------------------------------------------------
package asrow_pkg;

	localparam int MAX_TILE_WIDTH = 1024;
	localparam int MIN_TILE_WIDTH = 4;

	localparam int PIX_W   = 24;
	localparam int CH_W    = 8;
	localparam int CFG_W   = 11;
	localparam int CNT_W   = 11;
	localparam int CNT_MAX = (2 ** CNT_W) - 1;

	localparam int EW     = $clog2(MAX_TILE_WIDTH + 1);
	localparam int PTR_W  = $clog2(MAX_TILE_WIDTH);
	localparam int QW     = EW - 2;
	localparam int NUM_W  = (CFG_W > PTR_W) ? CFG_W : PTR_W;
	localparam int CC_W   = (CNT_W > EW) ? CNT_W : EW;

	localparam int SUM_W        = CH_W + 2;
	localparam int GRAY_W       = CH_W;
	localparam int GRAY_HALF    = GRAY_W / 2;
	localparam int RECIP3       = 683;
	localparam int RECIP3_W     = 10;
	localparam int RECIP3_SHIFT = 11;
	localparam int PROD_W       = SUM_W + RECIP3_W;
	localparam int DCMP_W       = (QW > GRAY_W + 1) ? QW : GRAY_W + 1;

	localparam int TILE_WIDTH_RST  = 64;
	localparam int TILE_OFFSET_RST = 0;

	localparam int CIDX_W = 1;

	typedef enum logic [CIDX_W-1:0] {
		REG_TILE_WIDTH  = 1'b0,
		REG_TILE_OFFSET = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [EW-1:0]    eff_w;
		logic             busy;
		logic [CFG_W-1:0] shift;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [PTR_W-1:0] value;
	} ptr_load_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic [EW-1:0] rem_a;
		logic [EW-1:0] rem_b;
	} rem_res_t;

	typedef struct packed {
		logic [PIX_W-1:0]  tile;
		logic [PTR_W-1:0]  ptr;
		logic [GRAY_W-1:0] depth;
		logic              is_tile;
		logic              eor;
	} depth_item_t;

endpackage

// ===== design/asrow_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asrow_in_if
// Input channel: one tile pixel, one depth pixel and a row end flag per
// request.
// ---------------------------------------------------------------------------
interface asrow_in_if import asrow_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] tile_pixel;
	logic [PIX_W-1:0] depth_pixel;
	logic             end_of_row;

	modport source (output valid, output tile_pixel, output depth_pixel,
		output end_of_row, input ready);
	modport sink (input valid, input tile_pixel, input depth_pixel,
		input end_of_row, output ready);
endinterface

// ===== design/asrow_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asrow_out_if
// Output channel: one stereogram pixel per request with its row flag and
// the column shift.
// ---------------------------------------------------------------------------
interface asrow_out_if import asrow_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_pixel;
	logic             row_last;
	logic [CFG_W-1:0] column_shift;

	modport source (output valid, output out_pixel, output row_last,
		output column_shift, input ready);
	modport sink (input valid, input out_pixel, input row_last,
		input column_shift, output ready);
endinterface

// ===== design/asrow_rem_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asrow_rem_unit
// Bit-serial restoring remainder unit with two lanes that share one
// divisor, one numerator bit per cycle.
// ---------------------------------------------------------------------------
module asrow_rem_unit import asrow_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num_a,
	input  logic [NUM_W-1:0] num_b,
	input  logic [EW-1:0]    divisor,
	output rem_res_t         res
);
	localparam int STEP_CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]      na_q, nb_q;
	logic [EW-1:0]         ra_q, rb_q;
	logic [STEP_CNT_W-1:0] count_q;
	logic                  busy_q, done_q;

	function automatic logic [EW-1:0] rem_step(input logic [EW-1:0] r, input logic b,
		input logic [EW-1:0] d);
		logic [EW:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[EW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= busy_q && (count_q == STEP_CNT_W'(1)) && !start;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= STEP_CNT_W'(NUM_W);
			end else if (busy_q) begin
				count_q <= count_q - STEP_CNT_W'(1);
				if (count_q == STEP_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			na_q <= num_a;
			nb_q <= num_b;
			ra_q <= '0;
			rb_q <= '0;
		end else if (busy_q) begin
			ra_q <= rem_step(ra_q, na_q[NUM_W-1], divisor);
			rb_q <= rem_step(rb_q, nb_q[NUM_W-1], divisor);
			na_q <= {na_q[NUM_W-2:0], 1'b0};
			nb_q <= {nb_q[NUM_W-2:0], 1'b0};
		end
	end

	assign res.busy  = busy_q;
	assign res.done  = done_q;
	assign res.rem_a = ra_q;
	assign res.rem_b = rb_q;
endmodule

// ===== design/asrow_cfg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asrow_cfg
// Configuration registers, effective tile width, column shift and the
// ring pointer reduction after a register write.
// ---------------------------------------------------------------------------
module asrow_cfg import asrow_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [PTR_W-1:0]  ring_ptr,
	output cfg_t              cfg,
	output ptr_load_t         ptr_load
);
	logic [CFG_W-1:0] tile_width_q, tile_offset_q, shift_q;
	logic             start_q;
	logic [EW-1:0]    eff_w;
	logic             off_neg;
	logic [CFG_W-1:0] off_abs;
	rem_res_t         rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= CFG_W'(TILE_WIDTH_RST);
			tile_offset_q <= CFG_W'(TILE_OFFSET_RST);
			start_q       <= 1'b0;
			shift_q       <= CFG_W'(TILE_WIDTH_RST);
		end else begin
			start_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_TILE_WIDTH:  tile_width_q  <= cfg_data;
					REG_TILE_OFFSET: tile_offset_q <= cfg_data;
					default: ;
				endcase
			end
			if (rem.done) begin
				if (off_neg && (rem.rem_a != '0)) begin
					shift_q <= CFG_W'(rem.rem_a);
				end else begin
					shift_q <= CFG_W'(eff_w - rem.rem_a);
				end
			end
		end
	end

	always_comb begin
		if (int'(tile_width_q) < MIN_TILE_WIDTH) begin
			eff_w = EW'(MIN_TILE_WIDTH);
		end else if (int'(tile_width_q) > MAX_TILE_WIDTH) begin
			eff_w = EW'(MAX_TILE_WIDTH);
		end else begin
			eff_w = EW'(tile_width_q);
		end
	end

	// The magnitude of the most negative offset still fits as an unsigned value.
	assign off_neg = tile_offset_q[CFG_W-1];
	assign off_abs = off_neg ? (~tile_offset_q + CFG_W'(1)) : tile_offset_q;

	asrow_rem_unit u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.num_a   (NUM_W'(off_abs)),
		.num_b   (NUM_W'(ring_ptr)),
		.divisor (eff_w),
		.res     (rem)
	);

	assign ptr_load.valid = rem.done;
	assign ptr_load.value = PTR_W'(rem.rem_b);

	assign cfg.eff_w = eff_w;
	assign cfg.busy  = cfg_we || start_q || rem.busy || rem.done;
	assign cfg.shift = shift_q;
endmodule

// ===== design/asrow_depth_pipe.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asrow_depth_pipe
// Column counter and ring pointer, then a four stage pipeline that turns
// the depth pixel into a repeat distance: gray level, then the remainder
// by a quarter of the tile width in two halves.
// ---------------------------------------------------------------------------
module asrow_depth_pipe import asrow_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_take,
	input  logic [PIX_W-1:0]  tile_pixel,
	input  logic [PIX_W-1:0]  depth_pixel,
	input  logic              end_of_row,
	input  logic [EW-1:0]     eff_w,
	input  ptr_load_t         ptr_load,
	output logic [PTR_W-1:0]  ring_ptr,
	output logic              item_valid,
	output depth_item_t       item
);
	typedef struct packed {
		logic [PIX_W-1:0] tile;
		logic [PTR_W-1:0] ptr;
		logic             is_tile;
		logic             eor;
	} carry_t;

	logic [CNT_W-1:0]     count_q;
	logic [PTR_W-1:0]     ring_ptr_q;
	logic [EW-1:0]        ptr_inc;
	logic                 is_tile_c;
	logic [SUM_W-1:0]     sum_c;
	logic [QW-1:0]        quarter;
	logic [PROD_W-1:0]    prod;
	logic [GRAY_W-1:0]    rem_hi, rem_lo;

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	carry_t               carry_s1, carry_s2, carry_s3, carry_s4;
	logic [SUM_W-1:0]     sum_s1;
	logic [GRAY_W-1:0]    gray_s2;
	logic [GRAY_W-1:0]    rem_s3;
	logic [GRAY_HALF-1:0] low_s3;
	logic [GRAY_W-1:0]    depth_s4;

	function automatic logic [GRAY_W-1:0] rem_step(input logic [GRAY_W-1:0] r,
		input logic b, input logic [QW-1:0] d);
		logic [DCMP_W-1:0] t;
		t = DCMP_W'({r, b});
		if (t >= DCMP_W'(d)) begin
			t = t - DCMP_W'(d);
		end
		return t[GRAY_W-1:0];
	endfunction

	assign is_tile_c = CC_W'(count_q) < CC_W'(eff_w);
	assign ptr_inc   = EW'(ring_ptr_q) + EW'(1);
	assign sum_c     = SUM_W'(depth_pixel[3*CH_W-1:2*CH_W]) +
		SUM_W'(depth_pixel[2*CH_W-1:CH_W]) + SUM_W'(depth_pixel[CH_W-1:0]);
	assign quarter   = eff_w[EW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ring_ptr_q <= '0;
		end else if (ptr_load.valid) begin
			ring_ptr_q <= ptr_load.value;
		end else if (in_take) begin
			if (end_of_row) begin
				count_q    <= '0;
				ring_ptr_q <= '0;
			end else begin
				if (count_q != CNT_W'(CNT_MAX)) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (ptr_inc >= eff_w) begin
					ring_ptr_q <= '0;
				end else begin
					ring_ptr_q <= PTR_W'(ptr_inc);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Division by three as a multiply by the scaled reciprocal, exact for all sums.
	assign prod = PROD_W'(sum_s1) * PROD_W'(RECIP3);

	always_comb begin
		rem_hi = '0;
		for (int i = 0; i < GRAY_HALF; i++) begin
			rem_hi = rem_step(rem_hi, gray_s2[GRAY_W-1-i], quarter);
		end
		rem_lo = rem_s3;
		for (int i = 0; i < GRAY_HALF; i++) begin
			rem_lo = rem_step(rem_lo, low_s3[GRAY_HALF-1-i], quarter);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s1.tile    <= tile_pixel;
			carry_s1.ptr     <= ring_ptr_q;
			carry_s1.is_tile <= is_tile_c;
			carry_s1.eor     <= end_of_row;
			sum_s1           <= sum_c;
			carry_s2         <= carry_s1;
			gray_s2          <= prod[RECIP3_SHIFT+GRAY_W-1:RECIP3_SHIFT];
			carry_s3         <= carry_s2;
			rem_s3           <= rem_hi;
			low_s3           <= gray_s2[GRAY_HALF-1:0];
			carry_s4         <= carry_s3;
			depth_s4         <= rem_lo;
		end
	end

	assign ring_ptr     = ring_ptr_q;
	assign item_valid   = valid_s4;
	assign item.tile    = carry_s4.tile;
	assign item.ptr     = carry_s4.ptr;
	assign item.depth   = depth_s4;
	assign item.is_tile = carry_s4.is_tile;
	assign item.eor     = carry_s4.eor;
endmodule

// ===== design/asrow_ring.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asrow_ring
// History ring memory: reads the repeated pixel, selects the output pixel,
// writes it back and holds it in the output register.
// ---------------------------------------------------------------------------
module asrow_ring import asrow_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             item_valid,
	input  depth_item_t      item,
	input  logic [EW-1:0]    eff_w,
	output logic             out_valid,
	output logic [PIX_W-1:0] out_pixel,
	output logic             row_last
);
	logic [PIX_W-1:0] mem [MAX_TILE_WIDTH];

	logic [EW:0]      rd_sum;
	logic [PTR_W-1:0] rd_addr;
	logic [PIX_W-1:0] pix;

	logic             valid_s5, valid_s6;
	logic [PIX_W-1:0] rdata_s5, tile_s5, pixel_s6;
	logic [PTR_W-1:0] ptr_s5;
	logic             is_tile_s5, eor_s5, eor_s6;

	assign rd_sum = (EW + 1)'(item.ptr) + (EW + 1)'(item.depth);

	always_comb begin
		if (rd_sum >= (EW + 1)'(eff_w)) begin
			rd_addr = PTR_W'(rd_sum - (EW + 1)'(eff_w));
		end else begin
			rd_addr = PTR_W'(rd_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_s5 <= mem[rd_addr];
		end
	end

	assign pix = is_tile_s5 ? tile_s5 : rdata_s5;

	always_ff @(posedge clk) begin
		if (en && valid_s5) begin
			mem[ptr_s5] <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s5 <= item_valid;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tile_s5    <= item.tile;
			ptr_s5     <= item.ptr;
			is_tile_s5 <= item.is_tile;
			eor_s5     <= item.eor;
			pixel_s6   <= pix;
			eor_s6     <= eor_s5;
		end
	end

	assign out_valid = valid_s6;
	assign out_pixel = pixel_s6;
	assign row_last  = eor_s6;
endmodule

// ===== design/autostereogram_row_engine_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// autostereogram_row_engine_top
// The engine takes one request per cycle unless the output stalls or a
// configuration update holds off the input; the pipeline is the counter
// stage, the divide-by-three multiply, two stages of the depth remainder,
// the history ring read and the output register, and a stalled output
// freezes the whole pipeline. The history ring is a single memory with one
// read and one write port and no clearing pass, so the first tile_width
// columns of every row must come before any repeat. After each configuration
// write the input is held off while a shared bit-serial remainder unit folds
// the ring pointer into the new tile width and recomputes the column shift.
// ---------------------------------------------------------------------------
module autostereogram_row_engine_top import asrow_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	asrow_in_if.sink          pix_in,
	asrow_out_if.source       pix_out,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);
	logic             en;
	logic             in_take;
	logic             out_valid;
	logic [PTR_W-1:0] ring_ptr;
	logic             item_valid;
	depth_item_t      item;
	cfg_t             cfg;
	ptr_load_t        ptr_load;

	assign en            = !out_valid || pix_out.ready;
	assign pix_in.ready  = en && !cfg.busy;
	assign in_take       = pix_in.valid && pix_in.ready;

	asrow_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ring_ptr  (ring_ptr),
		.cfg       (cfg),
		.ptr_load  (ptr_load)
	);

	asrow_depth_pipe u_depth (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_take     (in_take),
		.tile_pixel  (pix_in.tile_pixel),
		.depth_pixel (pix_in.depth_pixel),
		.end_of_row  (pix_in.end_of_row),
		.eff_w       (cfg.eff_w),
		.ptr_load    (ptr_load),
		.ring_ptr    (ring_ptr),
		.item_valid  (item_valid),
		.item        (item)
	);

	asrow_ring u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.item_valid (item_valid),
		.item       (item),
		.eff_w      (cfg.eff_w),
		.out_valid  (out_valid),
		.out_pixel  (pix_out.out_pixel),
		.row_last   (pix_out.row_last)
	);

	assign pix_out.valid        = out_valid;
	assign pix_out.column_shift = cfg.shift;

`ifndef ASSERT_OFF
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cfg.shift != '0) && (EW'(cfg.shift) <= cfg.eff_w))
		else $error("column shift outside one to tile width");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.busy |-> (EW'(ring_ptr) < cfg.eff_w))
		else $error("ring pointer not below tile width while accepting");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !pix_in.ready)
		else $error("input accepted right after a configuration write");
`endif
endmodule
